FILE: design/rbd_pkg.sv
// Package for the I/O register bus decoder: transfer types, command and operation
// codes, I/O register addresses and the internal memory reset contents.
// Depends on nothing; every other file uses it by scoped names.
`timescale 1ns / 1ps
package rbd_pkg;

    localparam int INTERNAL_BYTES = 32768;
    localparam int MEM_AW         = $clog2(INTERNAL_BYTES);
    localparam int DMA_BYTES      = 160;
    localparam int DMA_CNT_W      = $clog2(DMA_BYTES + 1);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0]        IO_PAGE_IDX  = 7'h7F;
    localparam logic [MEM_AW-1:0] DMA_DEST_IDX = 15'h7E00;

    localparam logic [15:0] ADDR_P1   = 16'hFF00;
    localparam logic [15:0] ADDR_SC   = 16'hFF02;
    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_TIMA = 16'hFF05;
    localparam logic [15:0] ADDR_TMA  = 16'hFF06;
    localparam logic [15:0] ADDR_TAC  = 16'hFF07;
    localparam logic [15:0] ADDR_IF   = 16'hFF0F;
    localparam logic [15:0] ADDR_NR10 = 16'hFF10;
    localparam logic [15:0] ADDR_NR30 = 16'hFF1A;
    localparam logic [15:0] ADDR_NR32 = 16'hFF1C;
    localparam logic [15:0] ADDR_NR41 = 16'hFF20;
    localparam logic [15:0] ADDR_NR44 = 16'hFF23;
    localparam logic [15:0] ADDR_NR52 = 16'hFF26;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_DMA  = 16'hFF46;

    localparam logic [7:0] MASK_P1     = 8'b1100_0000;
    localparam logic [7:0] MASK_SC     = 8'b0111_1110;
    localparam logic [7:0] MASK_IF     = 8'hE0;
    localparam logic [7:0] MASK_IF_LOW = 8'h1F;
    localparam logic [7:0] MASK_TAC    = 8'b1111_1000;
    localparam logic [7:0] MASK_HI     = 8'b1000_0000;
    localparam logic [7:0] MASK_NR30   = 8'b0111_1111;
    localparam logic [7:0] MASK_NR32   = 8'b1001_1111;
    localparam logic [7:0] MASK_NR44   = 8'b0011_1111;
    localparam logic [7:0] MASK_NR52   = 8'b0111_0000;

    typedef enum logic [2:0] {
        CMD_READ_BYTE  = 3'd0,
        CMD_WRITE_BYTE = 3'd1,
        CMD_READ_WORD  = 3'd2,
        CMD_WRITE_WORD = 3'd3,
        CMD_LATCH      = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CART,
        OP_READ_BYTE,
        OP_READ_WORD,
        OP_WRITE_WORD,
        OP_LATCH,
        OP_STORE,
        OP_DROP,
        OP_DIV,
        OP_TIMA,
        OP_TMA,
        OP_TAC,
        OP_DMA,
        OP_DMA_SKIP
    } op_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP1,
        ST_DMA,
        ST_STEP2
    } back_state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] address;
        logic [15:0] write_data;
        logic        timer_reload_a;
        logic        timer_reload_b;
    } in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        cart_request;
        logic        cart_write;
        logic        cart_word;
        logic [15:0] cart_address;
        logic [15:0] cart_data;
        logic        divider_reset;
        logic        tac_written;
        logic [7:0]  previous_tac;
        logic [7:0]  reload_value;
        logic        dma_skipped;
    } out_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [15:0] address;
        logic [15:0] data;
        logic [7:0]  value;
        logic        cart_write;
        logic        cart_word;
        logic        reload_a;
        logic        reload_b;
    } op_t;

    function automatic logic [7:0] reset_byte(logic [MEM_AW-1:0] idx);
        logic [7:0] v;
        v = 8'h00;
        if (idx[MEM_AW-1:8] == IO_PAGE_IDX) begin
            unique case (idx[7:0])
                8'h01, 8'h05, 8'h06, 8'h17, 8'h21, 8'h22, 8'h42, 8'h43,
                8'h45, 8'h4A, 8'h4B, 8'hFF: v = 8'h00;
                8'h02: v = 8'h7E;
                8'h07: v = 8'hF8;
                8'h0F: v = 8'hE1;
                8'h10: v = 8'h80;
                8'h11, 8'h14, 8'h19, 8'h1E, 8'h23: v = 8'hBF;
                8'h12, 8'h25: v = 8'hF3;
                8'h16: v = 8'h3F;
                8'h1A: v = 8'h7F;
                8'h1C: v = 8'h9F;
                8'h24: v = 8'h77;
                8'h26: v = 8'hF0;
                8'h40: v = 8'h91;
                8'h41: v = 8'h83;
                8'h44: v = 8'h90;
                8'h47: v = 8'hFC;
                default: v = 8'hFF;
            endcase
        end
        return v;
    endfunction

endpackage

FILE: design/io_register_bus_decoder.sv
// Top level of the I/O register bus decoder: front end, operation queue and back end.
// Depends on rbd_pkg, rbd_front, rbd_queue and rbd_back.
//
//   Channel   Ports                        Direction  Carries
//   input     s_valid, s_ready, s_payload  in         one bus access or timer event
//   result    m_valid, m_ready, m_payload  out        one result per access
//
// An access passes through the back end as take, memory access and result;
// a DMA write to the sprite table copies DMA_BYTES bytes, one byte per cycle through
// the single memory write port. After reset the back end walks the 32768-byte
// memory once, one byte a cycle, to load reset contents; s_ready stays low then.
// The queue lets the front end take up to two transfers while the back end or the
// result side is stalled.
`timescale 1ns / 1ps
module io_register_bus_decoder (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rbd_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output rbd_pkg::out_t m_payload
);

    logic         clearing;
    logic         q_ready;
    logic         q_push;
    rbd_pkg::op_t push_op;
    logic         q_pop;
    logic         q_valid;
    rbd_pkg::op_t pop_op;

    rbd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .clearing  (clearing),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_op      (push_op)
    );

    rbd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_op    (push_op),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_op     (pop_op)
    );

    rbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_op      (pop_op),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

FILE: design/rbd_front.sv
// Front end of the I/O register bus decoder: accepts input transfers and classifies
// them into operations for the back end. Depends on rbd_pkg.
`timescale 1ns / 1ps
module rbd_front (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  rbd_pkg::in_t s_payload,
    input  logic         clearing,
    input  logic         q_ready,
    output logic         q_push,
    output rbd_pkg::op_t q_op
);

    logic [15:0] a;
    logic [7:0]  val;
    logic        cart;
    logic        ign;
    logic        page_cart;

    always_comb begin
        a         = s_payload.address;
        val       = s_payload.write_data[7:0];
        cart      = (a <= 16'h7FFF) || (a >= 16'hA000 && a <= 16'hBFFF);
        ign       = (a == 16'hFF03) || (a >= 16'hFF08 && a <= 16'hFF0E) || (a == 16'hFF15)
                    || (a == 16'hFF1F) || (a >= 16'hFF27 && a <= 16'hFF29)
                    || (a >= 16'hFF4C && a <= 16'hFF7F);
        page_cart = (val <= 8'h7F) || (val >= 8'hA0 && val <= 8'hBF);

        q_op          = '0;
        q_op.kind     = rbd_pkg::OP_IDLE;
        q_op.address  = a;
        q_op.data     = s_payload.write_data;
        q_op.value    = val;
        q_op.reload_a = s_payload.timer_reload_a;
        q_op.reload_b = s_payload.timer_reload_b;

        if (s_payload.command <= rbd_pkg::CMD_WRITE_WORD && cart) begin
            q_op.kind       = rbd_pkg::OP_CART;
            q_op.cart_write = (s_payload.command == rbd_pkg::CMD_WRITE_BYTE)
                              || (s_payload.command == rbd_pkg::CMD_WRITE_WORD);
            q_op.cart_word  = (s_payload.command == rbd_pkg::CMD_READ_WORD)
                              || (s_payload.command == rbd_pkg::CMD_WRITE_WORD);
            if (s_payload.command == rbd_pkg::CMD_WRITE_BYTE) begin
                q_op.data = {8'h00, val};
            end else if (s_payload.command != rbd_pkg::CMD_WRITE_WORD) begin
                q_op.data = '0;
            end
        end else if (s_payload.command == rbd_pkg::CMD_READ_BYTE) begin
            q_op.kind = rbd_pkg::OP_READ_BYTE;
        end else if (s_payload.command == rbd_pkg::CMD_READ_WORD) begin
            q_op.kind = rbd_pkg::OP_READ_WORD;
        end else if (s_payload.command == rbd_pkg::CMD_WRITE_WORD) begin
            q_op.kind = rbd_pkg::OP_WRITE_WORD;
        end else if (s_payload.command == rbd_pkg::CMD_LATCH) begin
            q_op.kind = rbd_pkg::OP_LATCH;
        end else if (s_payload.command == rbd_pkg::CMD_WRITE_BYTE) begin
            q_op.kind = rbd_pkg::OP_STORE;
            priority if (a == rbd_pkg::ADDR_P1) begin
                q_op.value = val | rbd_pkg::MASK_P1;
            end else if (a == rbd_pkg::ADDR_SC) begin
                q_op.value = val | rbd_pkg::MASK_SC;
            end else if (ign) begin
                q_op.kind = rbd_pkg::OP_DROP;
            end else if (a == rbd_pkg::ADDR_DIV) begin
                q_op.kind  = rbd_pkg::OP_DIV;
                q_op.value = 8'h00;
            end else if (a == rbd_pkg::ADDR_TIMA) begin
                q_op.kind = rbd_pkg::OP_TIMA;
            end else if (a == rbd_pkg::ADDR_TAC) begin
                q_op.kind  = rbd_pkg::OP_TAC;
                q_op.value = val | rbd_pkg::MASK_TAC;
            end else if (a == rbd_pkg::ADDR_TMA) begin
                q_op.kind = rbd_pkg::OP_TMA;
            end else if (a == rbd_pkg::ADDR_IF) begin
                q_op.value = rbd_pkg::MASK_IF | (val & rbd_pkg::MASK_IF_LOW);
            end else if (a == rbd_pkg::ADDR_STAT || a == rbd_pkg::ADDR_NR10) begin
                q_op.value = val | rbd_pkg::MASK_HI;
            end else if (a == rbd_pkg::ADDR_NR30) begin
                q_op.value = val | rbd_pkg::MASK_NR30;
            end else if (a == rbd_pkg::ADDR_NR32) begin
                q_op.value = val | rbd_pkg::MASK_NR32;
            end else if (a == rbd_pkg::ADDR_NR41) begin
                q_op.value = val | rbd_pkg::MASK_P1;
            end else if (a == rbd_pkg::ADDR_NR44) begin
                q_op.value = val | rbd_pkg::MASK_NR44;
            end else if (a == rbd_pkg::ADDR_NR52) begin
                q_op.value = val | rbd_pkg::MASK_NR52;
            end else if (a == rbd_pkg::ADDR_DMA) begin
                q_op.kind = page_cart ? rbd_pkg::OP_DMA_SKIP : rbd_pkg::OP_DMA;
            end else begin
                q_op.value = val;
            end
        end
    end

    assign s_ready = q_ready && !clearing;
    assign q_push  = s_valid && s_ready;

`ifndef SYNTH
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !q_push) else $error("transfer accepted during memory clear");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_ready) else $error("push into a full queue");
    a_cart_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_op.cart_write) |-> (q_op.kind == rbd_pkg::OP_CART))
        else $error("cartridge write flag on an internal operation");
`endif

endmodule

FILE: design/rbd_queue.sv
// Short operation queue between the front and back ends of the bus decoder.
// Depends on rbd_pkg.
`timescale 1ns / 1ps
module rbd_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  rbd_pkg::op_t push_op,
    output logic         push_ready,
    input  logic         pop,
    output logic         pop_valid,
    output rbd_pkg::op_t pop_op
);

    rbd_pkg::op_t                      entry_reg [rbd_pkg::QUEUE_DEPTH];
    logic [rbd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rbd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rbd_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == rbd_pkg::QUEUE_PTR_W'(rbd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == rbd_pkg::QUEUE_PTR_W'(rbd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign push_ready = count_reg != rbd_pkg::QUEUE_CNT_W'(rbd_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = entry_reg[rd_ptr_reg];

`ifndef SYNTH
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid) else $error("pop from an empty queue");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> push_ready) else $error("push into a full queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rbd_pkg::QUEUE_CNT_W'(rbd_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

FILE: design/rbd_back.sv
// Back end of the bus decoder: internal memory with its reset clearing pass, I/O
// side effects, sprite DMA and the result register. Depends on rbd_pkg.
`timescale 1ns / 1ps
module rbd_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  rbd_pkg::op_t  q_op,
    output logic          q_pop,
    output logic          clearing,
    output logic          m_valid,
    input  logic          m_ready,
    output rbd_pkg::out_t m_payload
);

    localparam int AW = rbd_pkg::MEM_AW;

    logic [7:0] mem [rbd_pkg::INTERNAL_BYTES];

    rbd_pkg::back_state_t           state_reg, state_next;
    rbd_pkg::op_t                   op_reg, op_next;
    logic [AW-1:0]                  clr_reg, clr_next;
    logic [rbd_pkg::DMA_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]                     pend_reg, pend_next;
    logic [7:0]                     tac_reg, tac_next;
    logic                           out_valid_reg, out_valid_next;
    rbd_pkg::out_t                  out_reg, out_next;

    logic [7:0]    rda_reg, rdb_reg;
    logic [AW-1:0] ra, rb, wa;
    logic [7:0]    wd;
    logic          we;
    logic [AW-1:0] idx;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        tac_next       = tac_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        idx            = op_reg.address[AW-1:0];
        ra             = idx;
        rb             = idx + 1'b1;
        we             = 1'b0;
        wa             = idx;
        wd             = op_reg.value;

        unique case (state_reg)
            rbd_pkg::ST_CLEAR: begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = rbd_pkg::reset_byte(clr_reg);
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = rbd_pkg::ST_IDLE;
                end
            end
            rbd_pkg::ST_IDLE: begin
                if (q_valid && (!out_valid_reg || m_ready)) begin
                    q_pop      = 1'b1;
                    op_next    = q_op;
                    state_next = rbd_pkg::ST_STEP1;
                end
            end
            rbd_pkg::ST_STEP1: begin
                state_next = rbd_pkg::ST_STEP2;
                unique case (op_reg.kind)
                    rbd_pkg::OP_LATCH: ra = rbd_pkg::ADDR_TMA[AW-1:0];
                    rbd_pkg::OP_TAC:   ra = rbd_pkg::ADDR_TAC[AW-1:0];
                    rbd_pkg::OP_STORE, rbd_pkg::OP_DIV: we = 1'b1;
                    rbd_pkg::OP_WRITE_WORD: begin
                        we = 1'b1;
                        wd = op_reg.data[7:0];
                    end
                    rbd_pkg::OP_TIMA: begin
                        if (op_reg.reload_a) begin
                            pend_next = op_reg.value;
                        end else if (!op_reg.reload_b) begin
                            we = 1'b1;
                        end
                    end
                    rbd_pkg::OP_TMA: begin
                        we = op_reg.reload_b;
                        wa = rbd_pkg::ADDR_TIMA[AW-1:0];
                    end
                    rbd_pkg::OP_DMA: begin
                        cnt_next   = '0;
                        state_next = rbd_pkg::ST_DMA;
                    end
                    default: begin
                    end
                endcase
            end
            rbd_pkg::ST_DMA: begin
                ra       = {op_reg.value[AW-9:0], 8'(cnt_reg)};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0) begin
                    we = 1'b1;
                    wa = rbd_pkg::DMA_DEST_IDX + AW'(cnt_reg) - 1'b1;
                    wd = rda_reg;
                end
                if (cnt_reg == rbd_pkg::DMA_CNT_W'(rbd_pkg::DMA_BYTES)) begin
                    state_next = rbd_pkg::ST_STEP2;
                end
            end
            rbd_pkg::ST_STEP2: begin
                state_next = rbd_pkg::ST_IDLE;
                unique case (op_reg.kind)
                    rbd_pkg::OP_WRITE_WORD: begin
                        we = 1'b1;
                        wa = idx + 1'b1;
                        wd = op_reg.data[15:8];
                    end
                    rbd_pkg::OP_TMA: begin
                        we        = 1'b1;
                        wa        = rbd_pkg::ADDR_TMA[AW-1:0];
                        pend_next = op_reg.value;
                    end
                    rbd_pkg::OP_TAC: begin
                        we       = 1'b1;
                        wa       = rbd_pkg::ADDR_TAC[AW-1:0];
                        tac_next = rda_reg;
                    end
                    rbd_pkg::OP_LATCH: pend_next = rda_reg;
                    default: begin
                    end
                endcase
                out_valid_next         = 1'b1;
                out_next               = '0;
                out_next.previous_tac  = tac_next;
                out_next.reload_value  = pend_next;
                out_next.divider_reset = op_reg.kind == rbd_pkg::OP_DIV;
                out_next.tac_written   = op_reg.kind == rbd_pkg::OP_TAC;
                out_next.dma_skipped   = op_reg.kind == rbd_pkg::OP_DMA_SKIP;
                if (op_reg.kind == rbd_pkg::OP_READ_BYTE) begin
                    out_next.read_data = {8'h00, rda_reg};
                end else if (op_reg.kind == rbd_pkg::OP_READ_WORD) begin
                    out_next.read_data = {rdb_reg, rda_reg};
                end
                if (op_reg.kind == rbd_pkg::OP_CART) begin
                    out_next.cart_request = 1'b1;
                    out_next.cart_write   = op_reg.cart_write;
                    out_next.cart_word    = op_reg.cart_word;
                    out_next.cart_address = op_reg.address;
                    out_next.cart_data    = op_reg.data;
                end
            end
            default: state_next = rbd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rbd_pkg::ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= '0;
            tac_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            tac_reg       <= tac_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rda_reg <= mem[ra];
        rdb_reg <= mem[rb];
    end

    assign clearing  = state_reg == rbd_pkg::ST_CLEAR;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

`ifndef SYNTH
    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rbd_pkg::ST_STEP2) |-> !out_valid_reg)
        else $error("result register overwritten");
    a_no_pop_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == rbd_pkg::ST_IDLE))
        else $error("operation taken while busy");
    a_dma_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rbd_pkg::ST_DMA)
        |-> (cnt_reg <= rbd_pkg::DMA_CNT_W'(rbd_pkg::DMA_BYTES)))
        else $error("DMA count out of range");
    a_single_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.divider_reset && out_reg.tac_written))
        else $error("DIV and TAC pulses in one result");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the I/O register bus decoder: directed and random bus
// accesses, with a predictor of memory, reload and TAC state checked per transfer.
// Depends on rbd_pkg and the io_register_bus_decoder design files.
`timescale 1ns / 1ps
module tb;

    class access_scoreboard;
        logic [7:0]    mem [rbd_pkg::INTERNAL_BYTES];
        logic [7:0]    reload_byte;
        logic [7:0]    old_tac;
        rbd_pkg::out_t pending_results[$];
        int            mismatches;

        function void reset_state();
            for (int k = 0; k < rbd_pkg::INTERNAL_BYTES; k++) begin
                mem[k] = rbd_pkg::reset_byte(k[rbd_pkg::MEM_AW-1:0]);
            end
            reload_byte = 8'h00;
            old_tac = 8'h00;
            pending_results.delete();
            mismatches = 0;
        endfunction

        function logic [7:0] rd(logic [15:0] a);
            logic [15:0] d;
            d = a - 16'h8000;
            return mem[d[14:0]];
        endfunction

        function void wr(logic [15:0] a, logic [7:0] v);
            logic [15:0] d;
            d = a - 16'h8000;
            mem[d[14:0]] = v;
        endfunction

        function bit in_cart(logic [15:0] a);
            return a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF);
        endfunction

        function bit dropped(logic [15:0] a);
            return a == 16'hFF03 || (a >= 16'hFF08 && a <= 16'hFF0E) || a == 16'hFF15
                || a == 16'hFF1F || (a >= 16'hFF27 && a <= 16'hFF29)
                || (a >= 16'hFF4C && a <= 16'hFF7F);
        endfunction

        function void note_access(rbd_pkg::in_t x);
            rbd_pkg::out_t r;
            logic [7:0]    v;
            logic [15:0]   src;
            r = '0;
            v = x.write_data[7:0];
            if (x.command <= rbd_pkg::CMD_WRITE_WORD && in_cart(x.address)) begin
                r.cart_request = 1'b1;
                r.cart_write = x.command == rbd_pkg::CMD_WRITE_BYTE
                    || x.command == rbd_pkg::CMD_WRITE_WORD;
                r.cart_word = x.command >= rbd_pkg::CMD_READ_WORD;
                r.cart_address = x.address;
                if (x.command == rbd_pkg::CMD_WRITE_BYTE) r.cart_data = {8'h00, v};
                else if (x.command == rbd_pkg::CMD_WRITE_WORD) r.cart_data = x.write_data;
            end else if (x.command == rbd_pkg::CMD_READ_BYTE) begin
                r.read_data = {8'h00, rd(x.address)};
            end else if (x.command == rbd_pkg::CMD_READ_WORD) begin
                r.read_data = {rd(x.address + 16'd1), rd(x.address)};
            end else if (x.command == rbd_pkg::CMD_WRITE_WORD) begin
                wr(x.address, v);
                wr(x.address + 16'd1, x.write_data[15:8]);
            end else if (x.command == rbd_pkg::CMD_LATCH) begin
                reload_byte = rd(rbd_pkg::ADDR_TMA);
            end else if (x.command == rbd_pkg::CMD_WRITE_BYTE) begin
                if (x.address == rbd_pkg::ADDR_P1) wr(x.address, v | rbd_pkg::MASK_P1);
                else if (x.address == rbd_pkg::ADDR_SC) wr(x.address, v | rbd_pkg::MASK_SC);
                else if (dropped(x.address)) begin
                end else if (x.address == rbd_pkg::ADDR_DIV) begin
                    wr(x.address, 8'h00);
                    r.divider_reset = 1'b1;
                end else if (x.address == rbd_pkg::ADDR_TIMA) begin
                    if (x.timer_reload_a) reload_byte = v;
                    else if (!x.timer_reload_b) wr(x.address, v);
                end else if (x.address == rbd_pkg::ADDR_TAC) begin
                    old_tac = rd(x.address);
                    wr(x.address, v | rbd_pkg::MASK_TAC);
                    r.tac_written = 1'b1;
                end else if (x.address == rbd_pkg::ADDR_TMA) begin
                    if (x.timer_reload_b) wr(rbd_pkg::ADDR_TIMA, v);
                    wr(x.address, v);
                    reload_byte = v;
                end else if (x.address == rbd_pkg::ADDR_IF) begin
                    wr(x.address, rbd_pkg::MASK_IF | (v & rbd_pkg::MASK_IF_LOW));
                end else if (x.address == rbd_pkg::ADDR_STAT
                             || x.address == rbd_pkg::ADDR_NR10) begin
                    wr(x.address, v | rbd_pkg::MASK_HI);
                end else if (x.address == rbd_pkg::ADDR_NR30) begin
                    wr(x.address, v | rbd_pkg::MASK_NR30);
                end else if (x.address == rbd_pkg::ADDR_NR32) begin
                    wr(x.address, v | rbd_pkg::MASK_NR32);
                end else if (x.address == rbd_pkg::ADDR_NR41) begin
                    wr(x.address, v | rbd_pkg::MASK_P1);
                end else if (x.address == rbd_pkg::ADDR_NR44) begin
                    wr(x.address, v | rbd_pkg::MASK_NR44);
                end else if (x.address == rbd_pkg::ADDR_NR52) begin
                    wr(x.address, v | rbd_pkg::MASK_NR52);
                end else if (x.address == rbd_pkg::ADDR_DMA) begin
                    src = {v, 8'h00};
                    if (in_cart(src)) r.dma_skipped = 1'b1;
                    else begin
                        for (int i = 0; i < rbd_pkg::DMA_BYTES; i++) begin
                            wr(16'hFE00 + i[15:0], rd(src + i[15:0]));
                        end
                    end
                end else wr(x.address, v);
            end
            r.previous_tac = old_tac;
            r.reload_value = reload_byte;
            pending_results.push_back(r);
        endfunction

        function void check_result(rbd_pkg::out_t got);
            rbd_pkg::out_t e;
            bit            bad;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transfer: %h", got);
                return;
            end
            e = pending_results.pop_front();
            bad = e.read_data !== got.read_data || e.cart_request !== got.cart_request
                || e.cart_write !== got.cart_write || e.cart_word !== got.cart_word
                || e.cart_address !== got.cart_address || e.cart_data !== got.cart_data
                || e.divider_reset !== got.divider_reset
                || e.tac_written !== got.tac_written
                || e.previous_tac !== got.previous_tac
                || e.reload_value !== got.reload_value
                || e.dma_skipped !== got.dma_skipped;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result mismatch: expected %h, got %h", e, got);
                end
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    rbd_pkg::in_t     s_payload;
    logic             m_valid;
    logic             m_ready;
    rbd_pkg::out_t    m_payload;
    bit               stimulus_done;
    access_scoreboard board;

    io_register_bus_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_access(logic [2:0] c, logic [15:0] a, logic [15:0] d,
                               logic ra, logic rb);
        rbd_pkg::in_t x;
        int           g;
        g = gap_length();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        x.command = c;
        x.address = a;
        x.write_data = d;
        x.timer_reload_a = ra;
        x.timer_reload_b = rb;
        s_payload <= x;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_access(x);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_address();
        int p;
        p = $urandom_range(0, 99);
        if (p < 20) return 16'hFF00 + 16'($urandom_range(0, 127));
        if (p < 30) return 16'hFF80 + 16'($urandom_range(0, 127));
        if (p < 45) return 16'h8000 + 16'($urandom_range(0, 63));
        if (p < 55) return 16'hFE00 + 16'($urandom_range(0, 159));
        if (p < 60) return 16'h9FFF;
        if (p < 62) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    initial begin
        logic [15:0] a;
        logic [2:0]  c;
        logic [15:0] d;
        int          n;
        board = new();
        board.reset_state();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        stimulus_done = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_access(rbd_pkg::CMD_READ_BYTE, 16'h0000, 16'hFFFF, 1'b1, 1'b1);
        send_access(rbd_pkg::CMD_WRITE_WORD, 16'hBFFF, 16'hFFFF, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, 16'hA000, 16'h1234, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_READ_WORD, 16'h7FFF, 16'h0000, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_READ_WORD, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_WORD, 16'h9FFF, 16'hA55A, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_READ_WORD, 16'h9FFF, 16'h0000, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_P1, 16'h0000, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_DIV, 16'h00FF, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_TIMA, 16'h0011, 1'b1, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_TIMA, 16'h0022, 1'b0, 1'b1);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_TIMA, 16'h0033, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_TMA, 16'h0044, 1'b0, 1'b1);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_TAC, 16'h0005, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_TAC, 16'h0002, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_IF, 16'h00FF, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_LATCH, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, 16'hFF4C, 16'h0000, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, 16'hFF80, 16'h00AB, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_DMA, 16'h0080, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_DMA, 16'h00A5, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_WRITE_BYTE, rbd_pkg::ADDR_DMA, 16'h00FF, 1'b0, 1'b0);
        send_access(3'd5, 16'hFF00, 16'hFFFF, 1'b1, 1'b1);
        send_access(3'd7, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_access(rbd_pkg::CMD_READ_BYTE, 16'hFE9F, 16'h0000, 1'b0, 1'b0);
        for (n = 0; n < 1950; n++) begin
            c = 3'($urandom_range(0, 7));
            if (c > rbd_pkg::CMD_LATCH && $urandom_range(0, 3) != 0) begin
                c = rbd_pkg::CMD_WRITE_BYTE;
            end
            a = pick_address();
            d = 16'($urandom_range(0, 65535));
            if (c == rbd_pkg::CMD_WRITE_BYTE && $urandom_range(0, 40) == 0) begin
                a = rbd_pkg::ADDR_DMA;
                d[7:0] = 8'($urandom_range(0, 255));
            end
            if (c == rbd_pkg::CMD_WRITE_BYTE && a == rbd_pkg::ADDR_DMA
                && $urandom_range(0, 3) != 0) begin
                a = rbd_pkg::ADDR_NR52;
            end
            send_access(c, a, d, 1'($urandom), 1'($urandom));
        end
        s_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial begin
        int g;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            g = gap_length();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_payload);
    end

    initial begin
        wait (stimulus_done);
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
